// ----- design/bcg_pkg.sv -----
`timescale 1ns / 1ps
// shared constants and types for the cell growth step pipeline
// no dependencies

package bcg_pkg;

    localparam int unsigned DATA_W       = 32;
    localparam int unsigned Q30          = 30;
    localparam int unsigned SERIES_TERMS = 12;

    localparam logic [30:0] LOG2E_Q30 = 31'd1549082005;
    localparam logic [29:0] LN2_Q30   = 30'd744261118;
    localparam logic [63:0] TERM_CAP  = 64'h4000_0000_0000_0000;
    localparam logic [31:0] MAX_U32   = 32'hFFFF_FFFF;

    // floor(2^32 / k) for the series divisors
    localparam logic [32:0] RECIP [1:12] = '{
        33'h1_0000_0000, 33'd2147483648, 33'd1431655765, 33'd1073741824,
        33'd858993459,   33'd715827882,  33'd613566756,  33'd536870912,
        33'd477218588,   33'd429496729,  33'd390451572,  33'd357913941
    };

    typedef enum logic [2:0] {
        CFG_TIME_STEP       = 3'd0,
        CFG_MAX_UPTAKE_RATE = 3'd1,
        CFG_HALF_SATURATION = 3'd2,
        CFG_YIELD_FACTOR    = 3'd3,
        CFG_MAINTENANCE     = 3'd4,
        CFG_MEDIAN_VOLUME   = 3'd5,
        CFG_MIN_VOLUME      = 3'd6,
        CFG_DIVISION_VOLUME = 3'd7
    } t_cfg_reg;

    localparam logic [31:0] RST_TIME_STEP       = 32'd6554;
    localparam logic [31:0] RST_MAX_UPTAKE_RATE = 32'd65536;
    localparam logic [31:0] RST_HALF_SATURATION = 32'd65536;
    localparam logic [31:0] RST_YIELD_FACTOR    = 32'd32768;
    localparam logic [31:0] RST_MAINTENANCE     = 32'd655;
    localparam logic [31:0] RST_MEDIAN_VOLUME   = 32'd65536;
    localparam logic [31:0] RST_MIN_VOLUME      = 32'd32768;
    localparam logic [31:0] RST_DIVISION_VOLUME = 32'd131072;

    typedef struct packed {
        logic en;
        logic valid;
    } t_pipe_ctl;

endpackage

// ----- design/bcg_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per register stage
// depends on bcg_pkg

module bcg_div #(
    parameter int unsigned NUM_W  = 48,
    parameter int unsigned DEN_W  = 33,
    parameter int unsigned Q_W    = 17,
    parameter int unsigned SIDE_W = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  bcg_pkg::t_pipe_ctl   i_ctl,
    input  logic [NUM_W-1:0]     i_num,
    input  logic [DEN_W-1:0]     i_den,
    input  logic [SIDE_W-1:0]    i_side,
    output logic                 o_valid,
    output logic [Q_W-1:0]       o_quot,
    output logic [SIDE_W-1:0]    o_side
);

    logic [DEN_W-1:0]  w_rem  [0:Q_W];
    logic [Q_W-1:0]    w_low  [0:Q_W];
    logic [DEN_W-1:0]  w_den  [0:Q_W];
    logic [Q_W-1:0]    w_q    [0:Q_W];
    logic [SIDE_W-1:0] w_side [0:Q_W];
    logic              w_v    [0:Q_W];

    assign w_rem[0]  = DEN_W'(i_num[NUM_W-1:Q_W]);
    assign w_low[0]  = i_num[Q_W-1:0];
    assign w_den[0]  = i_den;
    assign w_q[0]    = '0;
    assign w_side[0] = i_side;
    assign w_v[0]    = i_ctl.valid;

    for (genvar gi = 0; gi < Q_W; gi++) begin : g_step
        logic [DEN_W:0]    w_trial;
        logic [DEN_W:0]    w_diff;
        logic              w_ge;
        logic [DEN_W-1:0]  r_rem;
        logic [Q_W-1:0]    r_low;
        logic [DEN_W-1:0]  r_den;
        logic [Q_W-1:0]    r_q;
        logic [SIDE_W-1:0] r_side;
        logic              r_v;

        assign w_trial = {w_rem[gi], w_low[gi][Q_W-1-gi]};
        assign w_diff  = w_trial - {1'b0, w_den[gi]};
        assign w_ge    = w_trial >= {1'b0, w_den[gi]};

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v <= 1'b0;
            end else if (i_ctl.en) begin
                r_v <= w_v[gi];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                r_rem  <= w_ge ? w_diff[DEN_W-1:0] : w_trial[DEN_W-1:0];
                r_low  <= w_low[gi];
                r_den  <= w_den[gi];
                r_q    <= {w_q[gi][Q_W-2:0], w_ge};
                r_side <= w_side[gi];
            end
        end

        assign w_rem[gi+1]  = r_rem;
        assign w_low[gi+1]  = r_low;
        assign w_den[gi+1]  = r_den;
        assign w_q[gi+1]    = r_q;
        assign w_side[gi+1] = r_side;
        assign w_v[gi+1]    = r_v;
    end

    assign o_valid = w_v[Q_W];
    assign o_quot  = w_q[Q_W];
    assign o_side  = w_side[Q_W];

endmodule

// ----- design/bcg_exp2.sv -----
`timescale 1ns / 1ps
// pipelined 2^f for f in [0,1), q30 taylor series, three stages per term
// depends on bcg_pkg

module bcg_exp2 #(
    parameter int unsigned SIDE_W = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcg_pkg::t_pipe_ctl i_ctl,
    input  logic [29:0]        i_frac,
    input  logic [SIDE_W-1:0]  i_side,
    output logic               o_valid,
    output logic [31:0]        o_pow,
    output logic [SIDE_W-1:0]  o_side
);

    localparam int unsigned NT = bcg_pkg::SERIES_TERMS;

    logic [59:0]       w_yp;
    logic [29:0]       r_y0;
    logic [SIDE_W-1:0] r_side0;
    logic              r_v0;

    logic [30:0]       w_term [0:NT];
    logic [31:0]       w_sum  [0:NT];
    logic [29:0]       w_y    [0:NT];
    logic [SIDE_W-1:0] w_side [0:NT];
    logic              w_v    [0:NT];

    assign w_yp = 60'(i_frac) * 60'(bcg_pkg::LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
        end else if (i_ctl.en) begin
            r_v0 <= i_ctl.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_y0    <= w_yp[59:30];
            r_side0 <= i_side;
        end
    end

    assign w_term[0] = 31'(1) << bcg_pkg::Q30;
    assign w_sum[0]  = 32'(1) << bcg_pkg::Q30;
    assign w_y[0]    = r_y0;
    assign w_side[0] = r_side0;
    assign w_v[0]    = r_v0;

    for (genvar gk = 1; gk <= NT; gk++) begin : g_term
        localparam logic [3:0] KV = 4'(gk);

        logic [60:0]       w_tp;
        logic [30:0]       ra_a;
        logic [31:0]       ra_sum;
        logic [29:0]       ra_y;
        logic [SIDE_W-1:0] ra_side;
        logic              ra_v;

        logic [63:0]       rb_m;
        logic [30:0]       rb_a;
        logic [31:0]       rb_sum;
        logic [29:0]       rb_y;
        logic [SIDE_W-1:0] rb_side;
        logic              rb_v;

        logic [30:0]       w_q0;
        logic [34:0]       w_qk;
        logic [34:0]       w_r;
        logic              w_ge;
        logic [30:0]       w_q;

        logic [30:0]       rc_term;
        logic [31:0]       rc_sum;
        logic [29:0]       rc_y;
        logic [SIDE_W-1:0] rc_side;
        logic              rc_v;

        assign w_tp = 61'(w_term[gk-1]) * 61'(w_y[gk-1]);
        assign w_q0 = rb_m[62:32];
        assign w_qk = 35'(w_q0) * 35'(KV);
        assign w_r  = 35'(rb_a) - w_qk;
        assign w_ge = w_r >= 35'(KV);
        assign w_q  = w_q0 + 31'(w_ge);

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                ra_v <= 1'b0;
                rb_v <= 1'b0;
                rc_v <= 1'b0;
            end else if (i_ctl.en) begin
                ra_v <= w_v[gk-1];
                rb_v <= ra_v;
                rc_v <= rb_v;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_ctl.en) begin
                ra_a    <= w_tp[60:30];
                ra_sum  <= w_sum[gk-1];
                ra_y    <= w_y[gk-1];
                ra_side <= w_side[gk-1];
                rb_m    <= 64'(ra_a) * 64'(bcg_pkg::RECIP[gk]);
                rb_a    <= ra_a;
                rb_sum  <= ra_sum;
                rb_y    <= ra_y;
                rb_side <= ra_side;
                rc_term <= w_q;
                rc_sum  <= rb_sum + 32'(w_q);
                rc_y    <= rb_y;
                rc_side <= rb_side;
            end
        end

        assign w_term[gk] = rc_term;
        assign w_sum[gk]  = rc_sum;
        assign w_y[gk]    = rc_y;
        assign w_side[gk] = rc_side;
        assign w_v[gk]    = rc_v;
    end

    assign o_valid = w_v[NT];
    assign o_pow   = w_sum[NT];
    assign o_side  = w_side[NT];

endmodule

// ----- design/bacterial_cell_growth_step_top.sv -----
`timescale 1ns / 1ps
// top level of the monod uptake and biomass growth step pipeline
// depends on bcg_pkg, bcg_div, bcg_exp2

// One cell record enters per clock and one result leaves per clock while the output
// is not stalled. The Monod ratio divider takes FRAC_BITS+1 stages, the growth
// divider 32+FRAC_BITS stages and the 2^f series 37 stages, the rest is
// multiply, subtract and saturate stages. A stalled output holds the whole
// pipeline. Configuration registers are written through their own port, one
// per beat, and must only change while no cell is in flight.

module bacterial_cell_growth_step_top #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_substrate_level,
    input  logic [31:0] i_cell_dry_mass,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_new_dry_mass,
    output logic [31:0] o_uptake_amount,
    output logic signed [31:0] o_growth_rate,
    output logic [31:0] o_cell_volume,
    output logic        o_dies,
    output logic        o_divides,
    output logic        o_saturated,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    localparam int unsigned F     = FRAC_BITS;
    localparam int unsigned MW    = 64 - F;
    localparam int unsigned HL    = (MW + 1) / 2;
    localparam int unsigned HH    = MW - HL;
    localparam int unsigned NW    = 33 - F;
    localparam int unsigned SHW   = NW + 2;
    localparam int unsigned S1_W  = 32 + 2 * MW + 1;
    localparam int unsigned S2_W  = 129;
    localparam int unsigned SE_W  = 97 + NW;

    logic [31:0] r_dt, r_vmax, r_km, r_ymax, r_maint, r_median, r_vmin, r_vdiv;
    logic        w_en;
    bcg_pkg::t_pipe_ctl w_ctl1, w_ctl2, w_ctle;

    assign w_en        = !(o_valid && i_stall);
    assign o_stall     = o_valid && i_stall;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt     <= bcg_pkg::RST_TIME_STEP;
            r_vmax   <= bcg_pkg::RST_MAX_UPTAKE_RATE;
            r_km     <= bcg_pkg::RST_HALF_SATURATION;
            r_ymax   <= bcg_pkg::RST_YIELD_FACTOR;
            r_maint  <= bcg_pkg::RST_MAINTENANCE;
            r_median <= bcg_pkg::RST_MEDIAN_VOLUME;
            r_vmin   <= bcg_pkg::RST_MIN_VOLUME;
            r_vdiv   <= bcg_pkg::RST_DIVISION_VOLUME;
        end else if (i_cfg_valid) begin
            unique case (bcg_pkg::t_cfg_reg'(i_cfg_index))
                bcg_pkg::CFG_TIME_STEP:       r_dt     <= i_cfg_data;
                bcg_pkg::CFG_MAX_UPTAKE_RATE: r_vmax   <= i_cfg_data;
                bcg_pkg::CFG_HALF_SATURATION: r_km     <= i_cfg_data;
                bcg_pkg::CFG_YIELD_FACTOR:    r_ymax   <= i_cfg_data;
                bcg_pkg::CFG_MAINTENANCE:     r_maint  <= i_cfg_data;
                bcg_pkg::CFG_MEDIAN_VOLUME:   r_median <= i_cfg_data;
                bcg_pkg::CFG_MIN_VOLUME:      r_vmin   <= i_cfg_data;
                bcg_pkg::CFG_DIVISION_VOLUME: r_vdiv   <= i_cfg_data;
            endcase
        end
    end

    // stage 1 and 2: input beat, denominator and mass products
    logic        r1_v, r2_v;
    logic [31:0] r1_s, r1_mass, r2_s, r2_mass;
    logic [32:0] r2_den;
    logic [63:0] r2_mvp, r2_mmp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
            r2_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= i_valid;
            r2_v <= r1_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_s    <= i_substrate_level;
            r1_mass <= i_cell_dry_mass;
            r2_s    <= r1_s;
            r2_mass <= r1_mass;
            r2_den  <= {1'b0, r_km} + {1'b0, r1_s};
            r2_mvp  <= {32'b0, r1_mass} * {32'b0, r_vmax};
            r2_mmp  <= {32'b0, r1_mass} * {32'b0, r_maint};
        end
    end

    // monod ratio divider
    logic            d1_v;
    logic [F:0]      d1_q;
    logic [S1_W-1:0] d1_side;

    assign w_ctl1 = '{en: w_en, valid: r2_v};

    bcg_div #(
        .NUM_W (32 + F),
        .DEN_W (33),
        .Q_W   (F + 1),
        .SIDE_W(S1_W)
    ) u_div_ratio (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl1),
        .i_num  ({r2_s, {F{1'b0}}}),
        .i_den  (r2_den),
        .i_side ({r2_mass, r2_mvp[63:F], r2_mmp[63:F], r2_den == 33'd0}),
        .o_valid(d1_v),
        .o_quot (d1_q),
        .o_side (d1_side)
    );

    logic [31:0]   d1_mass;
    logic [MW-1:0] d1_mv, d1_mm;
    logic          d1_zero;

    assign d1_mass = d1_side[S1_W-1 -: 32];
    assign d1_mv   = d1_side[2*MW:MW+1];
    assign d1_mm   = d1_side[MW:1];
    assign d1_zero = d1_side[0];

    // stage 3: uptake product and maintenance term partial products
    logic           r3_v, r4_v;
    logic [MW+F:0]  r3_prod;
    logic [HL+31:0] r3_plo;
    logic [HH+31:0] r3_phi;
    logic [31:0]    r3_mass;
    logic           r3_zero;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
            r4_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= d1_v;
            r4_v <= r3_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r3_prod <= (MW + F + 1)'(d1_mv) * (MW + F + 1)'(d1_q);
            r3_plo  <= (HL + 32)'(d1_mm[HL-1:0]) * (HL + 32)'(r_ymax);
            r3_phi  <= (HH + 32)'(d1_mm[MW-1:HL]) * (HH + 32)'(r_ymax);
            r3_mass <= d1_mass;
            r3_zero <= d1_zero;
        end
    end

    // stage 4: saturate uptake, assemble maintenance term
    logic [MW:0]  w_upsh;
    logic         w_upovf;
    logic [95:0]  w_t2f;
    logic [31:0]  r4_uptake, r4_mass;
    logic [63:0]  r4_t2;
    logic         r4_sat;

    assign w_upsh  = r3_prod[MW+F:F];
    assign w_upovf = |w_upsh[MW:32];
    assign w_t2f   = 96'({r3_phi, {HL{1'b0}}}) + 96'(r3_plo);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r4_uptake <= r3_zero ? 32'd0 : (w_upovf ? bcg_pkg::MAX_U32 : w_upsh[31:0]);
            r4_sat    <= !r3_zero && w_upovf;
            r4_t2     <= (|w_t2f[95:64]) ? bcg_pkg::TERM_CAP : 64'(w_t2f[63:F]);
            r4_mass   <= r3_mass;
        end
    end

    // growth divider, uptake over yield
    logic              d2_v;
    logic [31+F:0]     d2_q;
    logic [S2_W-1:0]   d2_side;

    assign w_ctl2 = '{en: w_en, valid: r4_v};

    bcg_div #(
        .NUM_W (33 + F),
        .DEN_W (32),
        .Q_W   (32 + F),
        .SIDE_W(S2_W)
    ) u_div_growth (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctl2),
        .i_num  ({1'b0, r4_uptake, {F{1'b0}}}),
        .i_den  (r_ymax),
        .i_side ({r4_mass, r4_uptake, r4_t2, r4_sat}),
        .o_valid(d2_v),
        .o_quot (d2_q),
        .o_side (d2_side)
    );

    logic [31:0] d2_mass, d2_uptake;
    logic [63:0] d2_t2;
    logic        d2_sat;

    assign d2_mass   = d2_side[128:97];
    assign d2_uptake = d2_side[96:65];
    assign d2_t2     = d2_side[64:1];
    assign d2_sat    = d2_side[0];

    // stage 5: growth rate
    logic [63:0]        w_t1;
    logic signed [64:0] w_gdiff;
    logic               w_ghi, w_glo, w_ycap;
    logic               r5_v, r6_v, r7_v;
    logic [31:0]        r5_g, r5_mass, r5_uptake;
    logic               r5_sat;

    assign w_ycap  = (r_ymax == 32'd0) && (d2_uptake != 32'd0);
    assign w_t1    = (r_ymax == 32'd0) ? (w_ycap ? bcg_pkg::TERM_CAP : 64'd0) : 64'(d2_q);
    assign w_gdiff = $signed({1'b0, w_t1}) - $signed({1'b0, d2_t2});
    assign w_ghi   = w_gdiff > 65'sd2147483647;
    assign w_glo   = w_gdiff < -65'sd2147483648;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
            r6_v <= 1'b0;
            r7_v <= 1'b0;
        end else if (w_en) begin
            r5_v <= d2_v;
            r6_v <= r5_v;
            r7_v <= r6_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r5_g      <= w_ghi ? 32'h7FFF_FFFF : (w_glo ? 32'h8000_0000 : w_gdiff[31:0]);
            r5_sat    <= d2_sat || w_ghi || w_glo || w_ycap;
            r5_mass   <= d2_mass;
            r5_uptake <= d2_uptake;
        end
    end

    // stage 6: mass step product and exponent product
    logic signed [64:0] r6_p;
    logic signed [62:0] r6_x;
    logic [31:0]        r6_g, r6_mass, r6_uptake;
    logic               r6_sat;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r6_p      <= $signed({1'b0, r_dt}) * $signed(r5_g);
            r6_x      <= $signed(r5_g) * $signed({1'b0, bcg_pkg::LOG2E_Q30});
            r6_g      <= r5_g;
            r6_mass   <= r5_mass;
            r6_uptake <= r5_uptake;
            r6_sat    <= r5_sat;
        end
    end

    // stage 7: new mass, split exponent
    logic signed [64:0] w_delta;
    logic signed [65:0] w_nm;
    logic               w_nmlo, w_nmhi;
    logic [31:0]        r7_nm, r7_uptake, r7_g;
    logic               r7_sat;
    logic [NW-1:0]      r7_n;
    logic [29:0]        r7_f;

    assign w_delta = r6_p >>> F;
    assign w_nm    = $signed({34'd0, r6_mass}) + $signed({w_delta[64], w_delta});
    assign w_nmlo  = w_nm[65];
    assign w_nmhi  = !w_nm[65] && (|w_nm[64:32]);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r7_nm     <= w_nmlo ? 32'd0 : (w_nmhi ? bcg_pkg::MAX_U32 : w_nm[31:0]);
            r7_sat    <= r6_sat || w_nmlo || w_nmhi;
            r7_uptake <= r6_uptake;
            r7_g      <= r6_g;
            r7_n      <= r6_x[62:F+30];
            r7_f      <= r6_x[F+29:F];
        end
    end

    // fractional power of two
    logic            e_v;
    logic [31:0]     e_pow;
    logic [SE_W-1:0] e_side;

    assign w_ctle = '{en: w_en, valid: r7_v};

    bcg_exp2 #(
        .SIDE_W(SE_W)
    ) u_exp2 (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctl  (w_ctle),
        .i_frac (r7_f),
        .i_side ({r7_nm, r7_uptake, r7_g, r7_sat, r7_n}),
        .o_valid(e_v),
        .o_pow  (e_pow),
        .o_side (e_side)
    );

    // stage 8: scale by median volume
    logic          r8_v, r9_v;
    logic [63:0]   r8_vm;
    logic [NW-1:0] r8_n;
    logic [31:0]   r8_nm, r8_uptake, r8_g;
    logic          r8_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
            r9_v <= 1'b0;
        end else if (w_en) begin
            r8_v <= e_v;
            r9_v <= r8_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r8_vm     <= {32'b0, r_median} * {32'b0, e_pow};
            r8_n      <= e_side[NW-1:0];
            r8_sat    <= e_side[NW];
            r8_g      <= e_side[NW+32:NW+1];
            r8_uptake <= e_side[NW+64:NW+33];
            r8_nm     <= e_side[NW+96:NW+65];
        end
    end

    // stage 9: power of two shift with saturation
    logic [SHW-1:0] w_sh, w_amt;
    logic [63:0]    w_lim, w_vr;
    logic [31:0]    w_vol;
    logic           w_vsat;
    logic [31:0]    r9_vol, r9_nm, r9_uptake, r9_g;
    logic           r9_sat;

    assign w_sh  = {{2{r8_n[NW-1]}}, r8_n} - SHW'(30);
    assign w_amt = SHW'(0) - w_sh;
    assign w_lim = 64'(bcg_pkg::MAX_U32) >> w_sh[4:0];
    assign w_vr  = r8_vm >> w_amt[5:0];

    always_comb begin
        w_vol  = 32'd0;
        w_vsat = 1'b0;
        priority if (r8_vm == 64'd0) begin
            w_vol = 32'd0;
        end else if (!w_sh[SHW-1]) begin
            if ((|w_sh[SHW-2:5]) || (r8_vm > w_lim)) begin
                w_vol  = bcg_pkg::MAX_U32;
                w_vsat = 1'b1;
            end else begin
                w_vol = r8_vm[31:0] << w_sh[4:0];
            end
        end else if (|w_amt[SHW-1:6]) begin
            w_vol = 32'd0;
        end else if (|w_vr[63:32]) begin
            w_vol  = bcg_pkg::MAX_U32;
            w_vsat = 1'b1;
        end else begin
            w_vol = w_vr[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r9_vol    <= w_vol;
            r9_sat    <= r8_sat || w_vsat;
            r9_nm     <= r8_nm;
            r9_uptake <= r8_uptake;
            r9_g      <= r8_g;
        end
    end

    // output register: thresholds and volume select
    logic w_div;

    assign w_div = r9_vol >= r_vdiv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (w_en) begin
            o_valid <= r9_v;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            o_new_dry_mass  <= r9_nm;
            o_uptake_amount <= r9_uptake;
            o_growth_rate   <= r9_g;
            o_cell_volume   <= w_div ? r_median : r9_vol;
            o_dies          <= r9_vol <= r_vmin;
            o_divides       <= w_div;
            o_saturated     <= r9_sat;
        end
    end

    a_stall_needs_beat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> o_valid)
        else $error("stall raised with no result beat pending");

    a_divide_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_divides |-> o_cell_volume == r_median)
        else $error("dividing cell does not report median volume");

    a_death_volume: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_dies && !o_divides |-> o_cell_volume <= r_vmin)
        else $error("dead cell volume above minimum");

    a_hold_pipeline: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |=> $stable(r9_vol) && $stable(r9_v))
        else $error("pipeline moved during output stall");

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// self-checking bench for the monod uptake and biomass growth step pipeline
// depends on bcg_pkg and bacterial_cell_growth_step_top

module tb;

    localparam int unsigned FB = 16;
    localparam int LAT = 80 + 2 * FB;

    typedef struct {
        logic [31:0] s;
        logic [31:0] m;
    } t_cell;

    typedef struct packed {
        logic [31:0] mass;
        logic [31:0] uptake;
        logic [31:0] growth;
        logic [31:0] vol;
        logic        dies;
        logic        divides;
        logic        sat;
    } t_growth;

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [31:0] i_substrate_level = 0;
    logic [31:0] i_cell_dry_mass = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [31:0] o_new_dry_mass;
    logic [31:0] o_uptake_amount;
    logic signed [31:0] o_growth_rate;
    logic [31:0] o_cell_volume;
    logic        o_dies;
    logic        o_divides;
    logic        o_saturated;
    logic        i_cfg_valid = 0;
    logic        o_cfg_ready;
    logic [2:0]  i_cfg_index = 0;
    logic [31:0] i_cfg_data = 0;

    logic [31:0] regs [8];
    t_cell   cells_q [$];
    t_growth growth_q [$];
    t_growth got, want;
    bit      quiet = 0;
    int      mismatches = 0;

    bacterial_cell_growth_step_top #(.FRAC_BITS(FB)) dut (.*);

    always #10 i_clk = ~i_clk;

    function automatic longint unsigned exp2_frac(longint unsigned f);
        longint unsigned y, term, sum;
        y = (f * 64'd744261118) >> 30;
        term = 64'd1 << 30;
        sum = term;
        for (int k = 1; k <= 12; k++) begin
            term = ((term * y) >> 30) / k;
            sum += term;
        end
        return sum;
    endfunction

    function automatic t_growth grow_cell(logic [31:0] s_in, logic [31:0] m_in);
        t_growth r;
        longint unsigned s, mass, den, ratio, mv, up, t1, t2, mm, ux, fr, v, vol;
        longint unsigned ymax;
        longint g, p, delta, nm, n, sh;
        bit sat;
        s = s_in;
        mass = m_in;
        ymax = regs[bcg_pkg::CFG_YIELD_FACTOR];
        sat = 0;
        up = 0;
        den = longint'(regs[bcg_pkg::CFG_HALF_SATURATION]) + s;
        if (den != 0) begin
            ratio = (s << FB) / den;
            mv = (mass * regs[bcg_pkg::CFG_MAX_UPTAKE_RATE]) >> FB;
            up = (mv * ratio) >> FB;
            if (up > 64'hFFFF_FFFF) begin
                up = 64'hFFFF_FFFF;
                sat = 1;
            end
        end
        if (ymax == 0) begin
            t1 = (up != 0) ? bcg_pkg::TERM_CAP : 0;
            if (up != 0) sat = 1;
        end else begin
            t1 = (up << FB) / ymax;
        end
        mm = (mass * regs[bcg_pkg::CFG_MAINTENANCE]) >> FB;
        if (ymax != 0 && mm > 64'hFFFF_FFFF_FFFF_FFFF / ymax) t2 = bcg_pkg::TERM_CAP;
        else t2 = (mm * ymax) >> FB;
        g = longint'(t1) - longint'(t2);
        if (g > 64'sd2147483647) begin
            g = 64'sd2147483647;
            sat = 1;
        end else if (g < -64'sd2147483648) begin
            g = -64'sd2147483648;
            sat = 1;
        end
        p = longint'(regs[bcg_pkg::CFG_TIME_STEP]) * g;
        delta = p >>> FB;
        nm = longint'(mass) + delta;
        if (nm < 0) begin
            nm = 0;
            sat = 1;
        end else if (nm > 64'sd4294967295) begin
            nm = 64'sd4294967295;
            sat = 1;
        end
        // volume law
        ux = longint'(g * 64'sd1549082005) + 64'h8000_0000_0000_0000;
        n = longint'(ux >> 46) - (64'sd1 <<< 17);
        fr = (ux & ((64'd1 << 46) - 1)) >> FB;
        v = longint'(regs[bcg_pkg::CFG_MEDIAN_VOLUME]) * exp2_frac(fr);
        sh = n - 30;
        if (v == 0) vol = 0;
        else if (sh >= 0) begin
            if (sh >= 32 || v > (64'hFFFF_FFFF >> sh)) begin
                vol = 64'hFFFF_FFFF;
                sat = 1;
            end else vol = v << sh;
        end else if (-sh >= 64) vol = 0;
        else begin
            vol = v >> (-sh);
            if (vol > 64'hFFFF_FFFF) begin
                vol = 64'hFFFF_FFFF;
                sat = 1;
            end
        end
        r.dies = vol <= regs[bcg_pkg::CFG_MIN_VOLUME];
        r.divides = vol >= regs[bcg_pkg::CFG_DIVISION_VOLUME];
        if (r.divides) vol = regs[bcg_pkg::CFG_MEDIAN_VOLUME];
        r.mass = nm[31:0];
        r.uptake = up[31:0];
        r.growth = g[31:0];
        r.vol = vol[31:0];
        r.sat = sat;
        return r;
    endfunction

    // driver: one cell beat at a time
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                growth_q.insert(growth_q.size(), grow_cell(i_substrate_level, i_cell_dry_mass));
            if (!i_valid || !o_stall) begin
                if (cells_q.size() > 0 && (quiet || $urandom_range(99) >= 18)) begin
                    i_valid <= 1;
                    i_substrate_level <= cells_q[0].s;
                    i_cell_dry_mass <= cells_q[0].m;
                    void'(cells_q.pop_front());
                end else begin
                    i_valid <= 0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                got = '{o_new_dry_mass, o_uptake_amount, o_growth_rate, o_cell_volume,
                        o_dies, o_divides, o_saturated};
                if (growth_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected result beat %p", got);
                end else begin
                    want = growth_q.pop_front();
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10) $display("mismatch exp %p got %p", want, got);
                    end
                end
            end
            i_stall <= !quiet && $urandom_range(99) < 18;
        end
    end

    task automatic write_reg(bcg_pkg::t_cfg_reg idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        regs[idx] = data;
        i_cfg_valid <= 0;
    endtask

    task automatic drain();
        while (!(cells_q.size() == 0 && growth_q.size() == 0 && !i_valid))
            @(posedge i_clk);
        repeat (LAT + 20) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick();
        case ($urandom_range(5))
            0: return 0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(32'h0004_0000);
            3: return $urandom_range(32'h0100_0000);
            default: return $urandom;
        endcase
    endfunction

    task automatic add_cell(logic [31:0] s, logic [31:0] m);
        cells_q.insert(cells_q.size(), t_cell'{s, m});
    endtask

    initial begin
        regs = '{bcg_pkg::RST_TIME_STEP, bcg_pkg::RST_MAX_UPTAKE_RATE,
                 bcg_pkg::RST_HALF_SATURATION, bcg_pkg::RST_YIELD_FACTOR,
                 bcg_pkg::RST_MAINTENANCE, bcg_pkg::RST_MEDIAN_VOLUME,
                 bcg_pkg::RST_MIN_VOLUME, bcg_pkg::RST_DIVISION_VOLUME};
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1;
        // directed cells at reset settings
        add_cell(0, 0);
        add_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cell(0, 32'hFFFF_FFFF);
        add_cell(32'hFFFF_FFFF, 0);
        add_cell(32'h0001_0000, 32'h0001_0000);
        add_cell(32'h0010_0000, 32'h0000_8000);
        add_cell(32'h0000_0001, 32'h0100_0000);
        add_cell(32'h0100_0000, 32'h0000_0100);
        drain();
        // empty denominator and zero yield
        write_reg(bcg_pkg::CFG_HALF_SATURATION, 0);
        write_reg(bcg_pkg::CFG_YIELD_FACTOR, 0);
        write_reg(bcg_pkg::CFG_TIME_STEP, 0);
        add_cell(0, 32'h0001_0000);
        add_cell(32'h0001_0000, 32'h0001_0000);
        add_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cell(0, 0);
        drain();
        // everything at maximum: large terms and saturation
        for (int i = 0; i < 8; i++) write_reg(bcg_pkg::t_cfg_reg'(i), 32'hFFFF_FFFF);
        add_cell(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_cell(32'h0000_0001, 32'hFFFF_FFFF);
        add_cell(32'h0001_0000, 32'h0000_0001);
        add_cell(0, 32'h8000_0000);
        drain();
        // both thresholds met
        write_reg(bcg_pkg::CFG_MIN_VOLUME, 32'hFFFF_FFFF);
        write_reg(bcg_pkg::CFG_DIVISION_VOLUME, 0);
        write_reg(bcg_pkg::CFG_YIELD_FACTOR, 32'h0000_8000);
        write_reg(bcg_pkg::CFG_MAINTENANCE, 0);
        add_cell(32'h0001_0000, 32'h0001_0000);
        add_cell(0, 0);
        add_cell(32'hFFFF_FFFF, 32'h0000_1000);
        drain();
        // random phases, each under a fresh setting
        for (int ph = 0; ph < 10; ph++) begin
            for (int i = 0; i < 8; i++) begin
                logic [31:0] d;
                case (ph % 3)
                    0: d = pick();
                    1: d = $urandom_range(32'h0004_0000);
                    default: d = $urandom;
                endcase
                if (ph == 1 || ph == 7) begin
                    d = (i == 6) ? 32'h0000_8000 :
                        (i == 7) ? 32'h0002_0000 : $urandom_range(32'h0002_0000);
                end
                write_reg(bcg_pkg::t_cfg_reg'(i), d);
            end
            quiet = (ph == 4);
            for (int i = 0; i < 190; i++) begin
                if ($urandom_range(3) == 0) add_cell(pick(), pick());
                else add_cell($urandom_range(32'h0008_0000), $urandom_range(32'h0008_0000));
            end
            drain();
            quiet = 0;
        end
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #20_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

// ----- bacterial_cell_growth_step_top.f -----
design/bcg_pkg.sv
design/bcg_div.sv
design/bcg_exp2.sv
design/bacterial_cell_growth_step_top.sv
test/tb.sv
